### hdl/cemap_pkg.sv
// Control event mapper package: transfer types, binding field layout,
// event/key/class codes and the binding reset table. No dependencies.
package cemap_pkg;

  localparam int NUM_BINDINGS  = 8;
  localparam int BINDING_COUNT = 8;
  localparam int IDX_W         = 3;
  localparam int BIND_W        = 40;
  localparam int DATA_W        = 64;
  localparam int ADDR_W        = 6;
  localparam int AXIS_LIMIT    = 1000;

  localparam logic [2:0] EV_OTHER    = 3'd0;
  localparam logic [2:0] EV_KEY_DOWN = 3'd1;
  localparam logic [2:0] EV_KEY_UP   = 3'd2;
  localparam logic [2:0] EV_BTN_DOWN = 3'd3;
  localparam logic [2:0] EV_BTN_UP   = 3'd4;
  localparam logic [2:0] EV_AXIS     = 3'd5;

  localparam logic [1:0] BK_NONE = 2'd0;
  localparam logic [1:0] BK_KEY  = 2'd1;
  localparam logic [1:0] BK_BTN  = 2'd2;
  localparam logic [1:0] BK_AXIS = 2'd3;

  localparam logic [2:0] KEY_NONE  = 3'd0;
  localparam logic [2:0] KEY_UP    = 3'd1;
  localparam logic [2:0] KEY_DOWN  = 3'd2;
  localparam logic [2:0] KEY_LEFT  = 3'd3;
  localparam logic [2:0] KEY_RIGHT = 3'd4;
  localparam logic [2:0] KEY_OK    = 3'd5;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_ON   = 2'd1;
  localparam logic [1:0] CLS_OFF  = 2'd2;
  localparam logic [1:0] CLS_DIR  = 2'd3;

  localparam logic [BIND_W-1:0] BIND_RESET [NUM_BINDINGS] = '{
    40'd274877927953, 40'd274877927713, 40'd274877927473, 40'd274877927233,
    40'd3409, 40'd0, 40'd0, 40'd0
  };

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [31:0]        key_code;
    logic [7:0]         control_index;
    logic signed [15:0] axis_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_class;
    logic [2:0] logical_key;
  } out_item_t;

  typedef struct packed {
    logic       stop;
    logic       hit;
    logic       changed;
    logic [4:0] mask_next;
    logic [2:0] dir_next;
    logic [1:0] cls;
    logic [2:0] key;
  } step_t;

  function automatic logic [4:0] target_bit(input logic [2:0] target);
    logic [4:0] bit_sel;
    bit_sel = 5'd0;
    if (target >= KEY_UP && target <= KEY_OK) begin
      bit_sel = 5'd1 << (target - 3'd1);
    end
    return bit_sel;
  endfunction

endpackage

### hdl/cemap_eval.sv
// Control event mapper binding unit: checks one binding against the held
// event and works out the level update. Depends on cemap_pkg.
module cemap_eval (
  input  logic [cemap_pkg::BIND_W-1:0] binding,
  input  cemap_pkg::in_item_t          item,
  input  logic [4:0]                   mask,
  input  logic [2:0]                   dir,
  output cemap_pkg::step_t             step
);

  logic [1:0]         bkind;
  logic signed [1:0]  bdir;
  logic [2:0]         btarget;
  logic [31:0]        bcode;
  logic [1:0]         ekind;
  logic               match;
  logic               pressed;
  logic signed [17:0] product;
  logic [4:0]         bit_sel;
  logic [4:0]         newlev;
  logic [4:0]         mask_n;
  logic [2:0]         dir_n;
  logic               changed;

  assign bkind   = binding[1:0];
  assign bdir    = binding[3:2];
  assign btarget = binding[6:4];
  assign bcode   = binding[39:8];
  assign product = $signed({{2{item.axis_value[15]}}, item.axis_value})
                 * $signed({{16{bdir[1]}}, bdir});
  assign bit_sel = cemap_pkg::target_bit(btarget);

  always_comb begin
    unique case (item.event_kind)
      cemap_pkg::EV_KEY_DOWN, cemap_pkg::EV_KEY_UP: ekind = cemap_pkg::BK_KEY;
      cemap_pkg::EV_BTN_DOWN, cemap_pkg::EV_BTN_UP: ekind = cemap_pkg::BK_BTN;
      cemap_pkg::EV_AXIS:                           ekind = cemap_pkg::BK_AXIS;
      default:                                      ekind = cemap_pkg::BK_NONE;
    endcase
  end

  always_comb begin
    match = (bkind == ekind) &&
            ((ekind == cemap_pkg::BK_KEY) ? (bcode == item.key_code)
                                          : (bcode == {24'd0, item.control_index}));
    unique case (ekind)
      cemap_pkg::BK_KEY: pressed = (item.event_kind == cemap_pkg::EV_KEY_DOWN);
      cemap_pkg::BK_BTN: pressed = (item.event_kind == cemap_pkg::EV_BTN_DOWN);
      default:           pressed = (product > 18'(cemap_pkg::AXIS_LIMIT));
    endcase
  end

  always_comb begin
    newlev  = pressed ? bit_sel : 5'd0;
    mask_n  = (mask & ~bit_sel) | newlev;
    dir_n   = dir;
    changed = 1'b0;
    if (newlev != (mask & bit_sel)) begin
      if (bit_sel[3:0] == 4'd0) begin
        changed = 1'b1;
      end else if (newlev != 5'd0) begin
        dir_n   = btarget;
        changed = 1'b1;
      end else if (btarget == dir) begin
        changed = 1'b1;
        priority if (mask_n[3]) begin
          dir_n = cemap_pkg::KEY_RIGHT;
        end else if (mask_n[2]) begin
          dir_n = cemap_pkg::KEY_LEFT;
        end else if (mask_n[0]) begin
          dir_n = cemap_pkg::KEY_UP;
        end else if (mask_n[1]) begin
          dir_n = cemap_pkg::KEY_DOWN;
        end else begin
          dir_n = cemap_pkg::KEY_NONE;
        end
      end
    end
  end

  always_comb begin
    step.stop      = (bkind == cemap_pkg::BK_NONE) || (ekind == cemap_pkg::BK_NONE);
    step.hit       = match && !step.stop;
    step.changed   = step.hit && changed;
    step.mask_next = mask_n;
    step.dir_next  = dir_n;
    if (bit_sel[3:0] == 4'd0) begin
      step.cls = pressed ? cemap_pkg::CLS_ON : cemap_pkg::CLS_OFF;
      step.key = btarget;
    end else begin
      step.cls = cemap_pkg::CLS_DIR;
      step.key = dir_n;
    end
  end

endmodule

### hdl/control_event_mapper_unit.sv
// Control event mapper top level: binding registers, APB port, scan
// sequencer and result register. Depends on cemap_pkg and cemap_eval.
//
//   channel   direction  handshake                 payload
//   event     in         event_valid / event_stall  cemap_pkg::in_item_t
//   result    out        result_valid / result_stall cemap_pkg::out_item_t
//   apb       in/out     psel / penable / pready    paddr, pwdata, prdata
//
// An event is scanned one binding per step (up to BINDING_COUNT), ended
// early by the first empty binding or at the first step for an unknown event
// kind; then the result is loaded and the block returns to idle before the
// next transfer is taken.
// The single binding unit is shared by every scan step.
// rst is synchronous and restores the default bindings and clears state.
// event_stall stays high from the accepted transfer until the result is
// loaded; a stalled result holds the block in the load cycle.
module control_event_mapper_unit #(
  parameter int BINDING_COUNT = cemap_pkg::BINDING_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         event_valid,
  output logic                         event_stall,
  input  cemap_pkg::in_item_t          event_data,
  output logic                         result_valid,
  input  logic                         result_stall,
  output cemap_pkg::out_item_t         result_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cemap_pkg::ADDR_W-1:0] paddr,
  input  logic [cemap_pkg::DATA_W-1:0] pwdata,
  output logic [cemap_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [cemap_pkg::BIND_W-1:0]    binding [cemap_pkg::NUM_BINDINGS];
  cemap_pkg::in_item_t             item;
  logic [4:0]                      mask;
  logic [2:0]                      dir;
  logic [cemap_pkg::IDX_W-1:0]     cnt;
  logic [1:0]                      cls;
  logic [2:0]                      key;
  cemap_pkg::step_t                step;
  logic                            accept;
  logic                            last;
  logic                            load;
  logic [cemap_pkg::IDX_W-1:0]     reg_idx;

  assign pready      = 1'b1;
  assign reg_idx     = paddr[cemap_pkg::ADDR_W-1:3];
  assign prdata      = {24'd0, binding[reg_idx]};
  assign event_stall = (state != S_IDLE);
  assign accept      = event_valid && !event_stall;
  assign last        = (cnt == cemap_pkg::IDX_W'(BINDING_COUNT - 1));
  assign load        = (state == S_HOLD) && (!result_valid || !result_stall);

  cemap_eval u_eval (
    .binding (binding[cnt]),
    .item    (item),
    .mask    (mask),
    .dir     (dir),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cemap_pkg::NUM_BINDINGS; i++) begin
        binding[i] <= cemap_pkg::BIND_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      binding[reg_idx] <= pwdata[cemap_pkg::BIND_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (step.stop || last) state_next = S_HOLD;
      S_HOLD: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mask  <= 5'd0;
      dir   <= cemap_pkg::KEY_NONE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == S_SCAN) begin
        if (step.hit) begin
          mask <= step.mask_next;
          dir  <= step.dir_next;
        end
        if (!step.stop && !last) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= event_data;
      cls  <= cemap_pkg::CLS_NONE;
      key  <= cemap_pkg::KEY_NONE;
    end else if (state == S_SCAN && step.changed) begin
      cls <= step.cls;
      key <= step.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data.event_class <= cls;
      result_data.logical_key <= key;
    end
  end

  a_dir_held: assert property (@(posedge clk) disable iff (rst)
    (dir != cemap_pkg::KEY_NONE) |-> (dir <= cemap_pkg::KEY_RIGHT) && mask[dir - 3'd1])
    else $error("current direction is not an active direction");

  a_dir_none: assert property (@(posedge clk) disable iff (rst)
    (mask[3:0] == 4'd0) |-> (dir == cemap_pkg::KEY_NONE))
    else $error("direction set with no direction active");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && (cnt == '0))
    else $error("scan did not start at the first binding");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt <= cemap_pkg::IDX_W'(BINDING_COUNT - 1)))
    else $error("scan index beyond binding count");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_HOLD))
    else $error("result loaded outside the load cycle");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for control_event_mapper_unit: directed table, then fixed and random
// binding phases with random source gaps and result stalls, checked against a local
// predictor. Depends on cemap_pkg and the RTL under hdl/.
module tb;
  import cemap_pkg::*;

  localparam int CLK_HALF  = 10;
  localparam int WD_LIMIT  = 4000;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } drow_t;

  logic                clk;
  logic                rst;
  logic                event_valid;
  logic                event_stall;
  in_item_t            event_data;
  logic                result_valid;
  logic                result_stall;
  out_item_t           result_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [BIND_W-1:0]   bind_shadow [NUM_BINDINGS];
  logic [4:0]          held_mask;
  logic [2:0]          held_dir;
  out_item_t           pending_results [$];
  drow_t               drows [$];
  int                  err_cnt;
  int                  stall_left;
  bit                  calm;

  control_event_mapper_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_data   (event_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic logic [4:0] key_bit(logic [2:0] k);
    if (k >= KEY_UP && k <= KEY_OK) begin
      return 5'd1 << (k - 3'd1);
    end
    return 5'd0;
  endfunction

  // Update one level; return 1 when it counts as a change.
  function automatic bit update_level(logic [2:0] tgt, bit pressed);
    logic [4:0] b;
    logic [4:0] nl;
    b  = key_bit(tgt);
    nl = pressed ? b : 5'd0;
    if (nl == (held_mask & b)) return 1'b0;
    held_mask = (held_mask & ~b) | nl;
    if (b[4]) return 1'b1;
    if (pressed) begin
      held_dir = tgt;
      return 1'b1;
    end
    if (tgt != held_dir) return 1'b0;
    if (held_mask[3]) held_dir = KEY_RIGHT;
    else if (held_mask[2]) held_dir = KEY_LEFT;
    else if (held_mask[0]) held_dir = KEY_UP;
    else if (held_mask[1]) held_dir = KEY_DOWN;
    else held_dir = KEY_NONE;
    return 1'b1;
  endfunction

  function automatic out_item_t map_event(in_item_t it);
    out_item_t         r;
    logic [1:0]        kind;
    logic [BIND_W-1:0] b;
    logic [2:0]        tgt;
    logic [4:0]        kb;
    bit                pressed;
    int                av;
    int                dv;
    r    = '{event_class: CLS_NONE, logical_key: KEY_NONE};
    case (it.event_kind)
      EV_KEY_DOWN, EV_KEY_UP: kind = BK_KEY;
      EV_BTN_DOWN, EV_BTN_UP: kind = BK_BTN;
      EV_AXIS:                kind = BK_AXIS;
      default:                kind = BK_NONE;
    endcase
    if (kind != BK_NONE) begin
      for (int i = 0; i < BINDING_COUNT; i++) begin
        b   = bind_shadow[i];
        tgt = b[6:4];
        if (b[1:0] == BK_NONE) break;
        if (b[1:0] != kind) continue;
        if (kind == BK_KEY) begin
          if (b[39:8] != it.key_code) continue;
          pressed = (it.event_kind == EV_KEY_DOWN);
        end else begin
          if (b[39:8] != {24'd0, it.control_index}) continue;
          if (kind == BK_BTN) begin
            pressed = (it.event_kind == EV_BTN_DOWN);
          end else begin
            av      = $signed(it.axis_value);
            dv      = $signed(b[3:2]);
            pressed = (av * dv) > AXIS_LIMIT;
          end
        end
        if (!update_level(tgt, pressed)) continue;
        kb = key_bit(tgt);
        if (kb[4]) begin
          r.event_class = pressed ? CLS_ON : CLS_OFF;
          r.logical_key = tgt;
        end else begin
          r.event_class = CLS_DIR;
          r.logical_key = held_dir;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [BIND_W-1:0] mk_bind(logic [1:0] kind, logic [1:0] dir,
                                                logic [2:0] tgt, logic [31:0] code);
    return {code, 1'b0, tgt, dir, kind};
  endfunction

  function automatic logic [BIND_W-1:0] draw_binding();
    logic [1:0]  kind;
    logic [2:0]  tgt;
    logic [31:0] code;
    kind = ($urandom_range(0, 9) == 0) ? BK_NONE : 2'($urandom_range(1, 3));
    tgt  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5));
    case ($urandom_range(0, 9))
      0:       code = $urandom;
      1:       code = 32'($urandom_range(256, 259));
      default: code = 32'($urandom_range(0, 3));
    endcase
    return {code, 1'($urandom), tgt, 2'($urandom), kind};
  endfunction

  function automatic in_item_t gen_event();
    in_item_t          it;
    logic [BIND_W-1:0] b;
    it.event_kind    = 3'($urandom_range(0, 7));
    it.key_code      = $urandom;
    it.control_index = 8'($urandom);
    it.axis_value    = 16'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      b = bind_shadow[$urandom_range(0, NUM_BINDINGS - 1)];
      case (b[1:0])
        BK_BTN: begin
          it.event_kind    = $urandom_range(0, 1) ? EV_BTN_DOWN : EV_BTN_UP;
          it.control_index = b[15:8];
        end
        BK_AXIS: begin
          it.event_kind    = EV_AXIS;
          it.control_index = b[15:8];
          case ($urandom_range(0, 7))
            0: it.axis_value = 16'sh7FFF;
            1: it.axis_value = 16'sh8000;
            2: it.axis_value = 16'sd1000;
            3: it.axis_value = 16'sd1001;
            4: it.axis_value = -16'sd1000;
            5: it.axis_value = -16'sd1001;
            default: ;
          endcase
        end
        default: begin
          it.event_kind = $urandom_range(0, 1) ? EV_KEY_DOWN : EV_KEY_UP;
          it.key_code   = b[39:8];
        end
      endcase
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic hold_off(int g);
    if (g > 0) begin
      @(negedge clk);
      event_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_event(in_item_t it, bit typed, out_item_t want);
    out_item_t p;
    @(negedge clk);
    event_valid <= 1'b1;
    event_data  <= it;
    @(posedge clk);
    while (event_stall) @(posedge clk);
    p = map_event(it);
    pending_results.push_back(typed ? want : p);
    hold_off(pick_gap());
  endtask

  task automatic wait_idle();
    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (BINDING_COUNT + 4) @(posedge clk);
  endtask

  task automatic write_binding(int idx, logic [BIND_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= {24'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bind_shadow[idx] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(logic [2:0] ev, logic [31:0] code, logic [7:0] idx,
                         logic [15:0] ax, bit typed, logic [1:0] cls, logic [2:0] key);
    drow_t d;
    d.stim  = '{event_kind: ev, key_code: code, control_index: idx, axis_value: ax};
    d.typed = typed;
    d.want  = '{event_class: cls, logical_key: key};
    drows.push_back(d);
  endtask

  task automatic run_rows();
    foreach (drows[i]) send_event(drows[i].stim, drows[i].typed, drows[i].want);
    drows.delete();
  endtask

  task automatic flag_mismatch(string what, out_item_t want, out_item_t got);
    if (err_cnt < MAX_SHOWN) begin
      $display("%0t %s: expected class %0d key %0d, got class %0d key %0d", $realtime,
               what, want.event_class, want.logical_key, got.event_class, got.logical_key);
    end
    err_cnt++;
  endtask

  always @(negedge clk) begin
    int n;
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      n = pick_gap();
      stall_left   = (n > 0) ? n - 1 : 0;
      result_stall <= (n > 0);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, result_data);
      end else begin
        want = pending_results.pop_front();
        if (result_data.event_class !== want.event_class ||
            result_data.logical_key !== want.logical_key) begin
          flag_mismatch("result mismatch", want, result_data);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WD_LIMIT) begin
      @(posedge clk);
      if ((event_valid && !event_stall) || (result_valid && !result_stall) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [BIND_W-1:0] v;
    int                n_items;
    rst          = 1'b1;
    event_valid  = 1'b0;
    event_data   = '0;
    result_stall = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_cnt      = 0;
    stall_left   = 0;
    calm         = 1'b0;
    held_mask    = 5'd0;
    held_dir     = KEY_NONE;
    foreach (bind_shadow[i]) bind_shadow[i] = BIND_RESET[i];
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // default bindings: arrows and return
    add_row(EV_OTHER, 32'h4000_0052, 8'd0, 16'd0, 1, CLS_NONE, KEY_NONE);
    add_row(3'd6, 32'h4000_0052, 8'd0, 16'd0, 1, CLS_NONE, KEY_NONE);
    add_row(3'd7, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1, CLS_NONE, KEY_NONE);
    add_row(EV_KEY_DOWN, 32'h4000_0052, 8'd0, 16'd0, 1, CLS_DIR, KEY_UP);
    add_row(EV_KEY_DOWN, 32'h4000_0050, 8'd0, 16'd0, 1, CLS_DIR, KEY_LEFT);
    add_row(EV_KEY_UP, 32'h4000_0052, 8'd0, 16'd0, 1, CLS_NONE, KEY_NONE);
    add_row(EV_KEY_DOWN, 32'h4000_004F, 8'd0, 16'd0, 1, CLS_DIR, KEY_RIGHT);
    add_row(EV_KEY_DOWN, 32'h4000_0051, 8'd0, 16'd0, 1, CLS_DIR, KEY_DOWN);
    add_row(EV_KEY_UP, 32'h4000_0051, 8'd0, 16'd0, 1, CLS_DIR, KEY_RIGHT);
    add_row(EV_KEY_UP, 32'h4000_004F, 8'd0, 16'd0, 1, CLS_DIR, KEY_LEFT);
    add_row(EV_KEY_UP, 32'h4000_0050, 8'd0, 16'd0, 1, CLS_DIR, KEY_NONE);
    add_row(EV_KEY_DOWN, 32'h0000_000D, 8'd0, 16'd0, 1, CLS_ON, KEY_OK);
    add_row(EV_KEY_DOWN, 32'h0000_000D, 8'd0, 16'd0, 1, CLS_NONE, KEY_NONE);
    add_row(EV_KEY_UP, 32'h0000_000D, 8'd0, 16'd0, 1, CLS_OFF, KEY_OK);
    add_row(EV_KEY_DOWN, 32'hFFFF_FFFF, 8'd0, 16'd0, 1, CLS_NONE, KEY_NONE);
    add_row(EV_BTN_DOWN, 32'h0, 8'd0, 16'd0, 1, CLS_NONE, KEY_NONE);
    run_rows();
    wait_idle();

    // buttons, axes, keyless targets and wide codes
    write_binding(0, mk_bind(BK_AXIS, 2'd1, KEY_UP, 32'd0));
    write_binding(1, mk_bind(BK_AXIS, 2'd3, KEY_DOWN, 32'd0));
    write_binding(2, mk_bind(BK_BTN, 2'd0, KEY_OK, 32'd255));
    write_binding(3, mk_bind(BK_BTN, 2'd0, KEY_LEFT, 32'd256));
    write_binding(4, mk_bind(BK_KEY, 2'd0, 3'd6, 32'hFFFF_FFFF));
    write_binding(5, mk_bind(BK_AXIS, 2'd2, KEY_RIGHT, 32'd1));
    write_binding(6, mk_bind(BK_BTN, 2'd0, KEY_NONE, 32'd7));
    write_binding(7, '0);
    add_row(EV_AXIS, 32'd0, 8'd0, 16'sh7FFF, 0, CLS_NONE, KEY_NONE);
    add_row(EV_AXIS, 32'd0, 8'd0, 16'sh8000, 0, CLS_NONE, KEY_NONE);
    add_row(EV_AXIS, 32'd0, 8'd0, 16'sd1000, 0, CLS_NONE, KEY_NONE);
    add_row(EV_AXIS, 32'd0, 8'd0, 16'sd1001, 0, CLS_NONE, KEY_NONE);
    add_row(EV_AXIS, 32'd0, 8'd0, -16'sd1001, 0, CLS_NONE, KEY_NONE);
    add_row(EV_BTN_DOWN, 32'd0, 8'd255, 16'd0, 0, CLS_NONE, KEY_NONE);
    add_row(EV_BTN_UP, 32'd0, 8'd255, 16'd0, 0, CLS_NONE, KEY_NONE);
    add_row(EV_BTN_DOWN, 32'd0, 8'd0, 16'd0, 0, CLS_NONE, KEY_NONE);
    add_row(EV_KEY_DOWN, 32'hFFFF_FFFF, 8'd0, 16'd0, 0, CLS_NONE, KEY_NONE);
    add_row(EV_AXIS, 32'd0, 8'd1, 16'sh8000, 0, CLS_NONE, KEY_NONE);
    add_row(EV_AXIS, 32'd0, 8'd1, 16'd0, 0, CLS_NONE, KEY_NONE);
    add_row(EV_BTN_DOWN, 32'd0, 8'd7, 16'd0, 0, CLS_NONE, KEY_NONE);
    run_rows();
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < NUM_BINDINGS; i++) begin
        case (ph)
          0:       v = '0;
          1:       v = '1;
          2:       v = BIND_RESET[i];
          default: v = draw_binding();
        endcase
        write_binding(i, v);
      end
      n_items = (ph < 2) ? 30 : 105;
      for (int k = 0; k < n_items; k++) begin
        if (k % 35 == 0) calm = ($urandom_range(0, 3) == 0);
        send_event(gen_event(), 0, '0);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### control_event_mapper_unit.f
hdl/cemap_pkg.sv
hdl/cemap_eval.sv
hdl/control_event_mapper_unit.sv
tb/tb.sv
